// File: rtl/mccac_pkg.sv
// ----------------------------------------------------------------------------
// mccac_pkg
// Shared types, constants and the generator step for the Monte Carlo
// cubic area counter.
// ----------------------------------------------------------------------------
package mccac_pkg;

    localparam int STATE_W = 31;
    localparam int COUNT_W = 16;
    localparam int MULT_W  = 15;
    localparam int TOL_W   = 14;

    localparam logic [STATE_W-1:0] LCG_MOD    = 31'd2147483647;
    localparam logic [MULT_W-1:0]  LCG_MUL    = 15'd16807;
    localparam logic [TOL_W-1:0]   TOL_SCALE  = 14'd10000;
    localparam logic [STATE_W-1:0] SEED_RESET = 31'd7994808;
    localparam logic [COUNT_W-1:0] SPT_RESET  = 16'd100;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPT  = 1'b1;

    // limb-serial wide arithmetic
    localparam int LIMB_W     = 32;
    localparam int LIMBS      = 4;
    localparam int WIDE_W     = LIMB_W * LIMBS;
    localparam int LIMB_IDX_W = $clog2(LIMBS);

    // 10000 * M^2 and M^3
    localparam logic [WIDE_W-1:0] LHS_K =
        WIDE_W'(TOL_SCALE) * WIDE_W'(LCG_MOD) * WIDE_W'(LCG_MOD);
    localparam logic [WIDE_W-1:0] CUBE_M =
        WIDE_W'(LCG_MOD) * WIDE_W'(LCG_MOD) * WIDE_W'(LCG_MOD);

    // queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic                reseed;
        logic [STATE_W-1:0]  sx;
        logic [STATE_W-1:0]  sy;
    } sample_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // one step of state' = 16807 * state mod (2^31 - 1)
    function automatic logic [STATE_W-1:0] lcg_next(input logic [STATE_W-1:0] s);
        logic [STATE_W+MULT_W-1:0] p;
        logic [STATE_W:0]          f;
        logic [STATE_W:0]          r;
        p = (STATE_W+MULT_W)'(s) * (STATE_W+MULT_W)'(LCG_MUL);
        // 2^31 = 1 mod M: fold the high part down, one subtract is enough
        f = (STATE_W+1)'(p[STATE_W-1:0]) + (STATE_W+1)'(p[STATE_W+MULT_W-1:STATE_W]);
        if (f >= (STATE_W+1)'(LCG_MOD))
        begin
            r = f - (STATE_W+1)'(LCG_MOD);
        end
        else
        begin
            r = f;
        end
        return r[STATE_W-1:0];
    endfunction

endpackage

// File: rtl/mccac_front.sv
// ----------------------------------------------------------------------------
// mccac_front
// Accepts sample items, applies reseed and draws sx, sy from the generator.
// ----------------------------------------------------------------------------
module mccac_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    input  logic                         reseed,
    output logic                         sample_stall,
    input  logic [mccac_pkg::STATE_W-1:0] seed,
    input  mccac_pkg::q_status_t         q_stat,
    output logic                         push,
    output mccac_pkg::sample_t           push_data
);

    import mccac_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_SY   = 2'b10
    } front_state_t;

    front_state_t       state_reg, state_next;
    logic [STATE_W-1:0] gen_reg, gen_next;
    logic [STATE_W-1:0] sx_reg, sx_next;
    logic               rs_reg, rs_next;
    logic               accept;
    logic [STATE_W-1:0] sy;

    assign sample_stall = (state_reg != F_IDLE) || q_stat.full;
    assign accept       = sample_valid && !sample_stall;
    assign sy           = lcg_next(sx_reg);

    always_comb
    begin
        state_next = state_reg;
        gen_next   = gen_reg;
        sx_next    = sx_reg;
        rs_next    = rs_reg;
        push       = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    sx_next    = lcg_next(reseed ? seed : gen_reg);
                    rs_next    = reseed;
                    state_next = F_SY;
                end
            end
            F_SY:
            begin
                // slot was free at accept and only this side fills the queue
                push       = 1'b1;
                gen_next   = sy;
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign push_data.reseed = rs_reg;
    assign push_data.sx     = sx_reg;
    assign push_data.sy     = sy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            gen_reg   <= SEED_RESET;
        end
        else
        begin
            state_reg <= state_next;
            gen_reg   <= gen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg <= sx_next;
        rs_reg <= rs_next;
    end

endmodule

// File: rtl/mccac_queue.sv
// ----------------------------------------------------------------------------
// mccac_queue
// Short FIFO of drawn samples between the front and the back.
// ----------------------------------------------------------------------------
module mccac_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mccac_pkg::sample_t   push_data,
    input  logic                 pop,
    output mccac_pkg::sample_t   head,
    output mccac_pkg::q_status_t q_stat
);

    import mccac_pkg::*;

    sample_t           entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = entry_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QDEPTH - 1))
        begin
            return '0;
        end
        return p + QPTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/mccac_back.sv
// ----------------------------------------------------------------------------
// mccac_back
// Exact hit test 10000*sy*M^2 <= 10000*sx^3 + M^3 on a limb-serial
// multiplier, trial counters and the result register.
// ----------------------------------------------------------------------------
module mccac_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  mccac_pkg::q_status_t         q_stat,
    input  mccac_pkg::sample_t           head,
    output logic                         pop,
    input  logic [mccac_pkg::COUNT_W-1:0] samples_per_trial,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [mccac_pkg::COUNT_W-1:0] hit_count
);

    import mccac_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL  = 4'b0010,
        B_ADD  = 4'b0100,
        B_CMP  = 4'b1000
    } back_state_t;

    localparam logic [1:0] PASS_LHS  = 2'd0;
    localparam logic [1:0] PASS_SQ   = 2'd1;
    localparam logic [1:0] PASS_CUBE = 2'd2;

    localparam int PROD_W = LIMB_W + STATE_W;

    back_state_t           state_reg, state_next;
    logic [WIDE_W-1:0]     w_reg, w_next;
    logic [WIDE_W-1:0]     lhs_reg, lhs_next;
    logic [STATE_W-1:0]    mul_reg, mul_next;
    logic [STATE_W-1:0]    sx_reg, sx_next;
    logic                  rs_reg, rs_next;
    logic [LIMB_W-1:0]     carry_reg, carry_next;
    logic [LIMB_IDX_W-1:0] limb_reg, limb_next;
    logic [1:0]            pass_reg, pass_next;
    logic [COUNT_W-1:0]    smp_cnt_reg, smp_cnt_next;
    logic [COUNT_W-1:0]    hit_cnt_reg, hit_cnt_next;
    logic                  result_valid_reg, result_valid_next;
    logic [COUNT_W-1:0]    hit_count_reg, hit_count_next;

    logic [PROD_W-1:0]         prod;
    logic [2*LIMB_W-1:0]       limb_sum;
    logic [WIDE_W-1:0]         w_shift;
    logic [STATE_W+TOL_W-1:0]  sx_tol;
    logic                      out_free;
    logic                      hit;
    logic [COUNT_W-1:0]        base_s, base_h, smp_n, hit_n, limit;

    // one limb a cycle: low limb times scalar plus carry, rotate in at the top
    assign prod     = PROD_W'(w_reg[LIMB_W-1:0]) * PROD_W'(mul_reg);
    assign limb_sum = (2*LIMB_W)'(prod) + (2*LIMB_W)'(carry_reg);
    assign w_shift  = {limb_sum[LIMB_W-1:0], w_reg[WIDE_W-1:LIMB_W]};
    assign sx_tol   = (STATE_W+TOL_W)'(sx_reg) * (STATE_W+TOL_W)'(TOL_SCALE);

    assign out_free = !result_valid_reg || !result_stall;
    assign hit      = (lhs_reg <= w_reg);
    assign base_s   = rs_reg ? '0 : smp_cnt_reg;
    assign base_h   = rs_reg ? '0 : hit_cnt_reg;
    assign smp_n    = base_s + COUNT_W'(1);
    assign hit_n    = base_h + COUNT_W'(hit);
    assign limit    = (samples_per_trial == '0) ? COUNT_W'(1) : samples_per_trial;

    always_comb
    begin
        state_next        = state_reg;
        w_next            = w_reg;
        lhs_next          = lhs_reg;
        mul_next          = mul_reg;
        sx_next           = sx_reg;
        rs_next           = rs_reg;
        carry_next        = carry_reg;
        limb_next         = limb_reg;
        pass_next         = pass_reg;
        smp_cnt_next      = smp_cnt_reg;
        hit_cnt_next      = hit_cnt_reg;
        result_valid_next = result_valid_reg && result_stall;
        hit_count_next    = hit_count_reg;
        pop               = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    sx_next    = head.sx;
                    rs_next    = head.reseed;
                    w_next     = LHS_K;
                    mul_next   = head.sy;
                    carry_next = '0;
                    limb_next  = '0;
                    pass_next  = PASS_LHS;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                w_next     = w_shift;
                carry_next = limb_sum[2*LIMB_W-1:LIMB_W];
                limb_next  = limb_reg + LIMB_IDX_W'(1);
                if (limb_reg == LIMB_IDX_W'(LIMBS - 1))
                begin
                    carry_next = '0;
                    limb_next  = '0;
                    case (pass_reg)
                        PASS_LHS:
                        begin
                            lhs_next  = w_shift;
                            w_next    = WIDE_W'(sx_tol);
                            mul_next  = sx_reg;
                            pass_next = PASS_SQ;
                        end
                        PASS_SQ:
                        begin
                            pass_next = PASS_CUBE;
                        end
                        default:
                        begin
                            state_next = B_ADD;
                        end
                    endcase
                end
            end
            B_ADD:
            begin
                w_next     = w_reg + CUBE_M;
                state_next = B_CMP;
            end
            B_CMP:
            begin
                if (out_free)
                begin
                    if (smp_n >= limit)
                    begin
                        result_valid_next = 1'b1;
                        hit_count_next    = hit_n;
                        smp_cnt_next      = '0;
                        hit_cnt_next      = '0;
                    end
                    else
                    begin
                        smp_cnt_next = smp_n;
                        hit_cnt_next = hit_n;
                    end
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign hit_count    = hit_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            limb_reg         <= '0;
            pass_reg         <= PASS_LHS;
            smp_cnt_reg      <= '0;
            hit_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            limb_reg         <= limb_next;
            pass_reg         <= pass_next;
            smp_cnt_reg      <= smp_cnt_next;
            hit_cnt_reg      <= hit_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg         <= w_next;
        lhs_reg       <= lhs_next;
        mul_reg       <= mul_next;
        sx_reg        <= sx_next;
        rs_reg        <= rs_next;
        carry_reg     <= carry_next;
        hit_count_reg <= hit_count_next;
    end

endmodule

// File: rtl/monte_carlo_cubic_area_counter_core.sv
// ----------------------------------------------------------------------------
// monte_carlo_cubic_area_counter_core
// Hit-or-miss Monte Carlo area under y = x^3 with a Park-Miller generator.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------
//  sample   | sample_valid/sample_stall | reseed
//  result   | result_valid/result_stall | hit_count (one item per trial)
//  config   | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
//  The front draws sx on taking an item and sy in its F_SY state (two chained
//  generator steps). The back runs three 4-limb passes on its 32x31 limb-serial
//  multiplier, then does add, compare and count; it sets the rate.
//  A 2-entry queue decouples the two; a stalled result holds the back in its
//  count step only. cfg_ready is always high. Async reset, no clearing pass.
// ----------------------------------------------------------------------------
module monte_carlo_cubic_area_counter_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic                            reseed,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [mccac_pkg::COUNT_W-1:0]    hit_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mccac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mccac_pkg::CFG_DATA_W-1:0] cfg_data
);

    import mccac_pkg::*;

    logic [STATE_W-1:0] seed_reg;
    logic [COUNT_W-1:0] spt_reg;
    logic               push, pop;
    sample_t            push_data, head;
    q_status_t          q_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
            spt_reg  <= SPT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SEED: seed_reg <= cfg_data[STATE_W-1:0];
                CFG_SPT:  spt_reg  <= cfg_data[COUNT_W-1:0];
                default:  ;
            endcase
        end
    end

    mccac_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .reseed       (reseed),
        .sample_stall (sample_stall),
        .seed         (seed_reg),
        .q_stat       (q_stat),
        .push         (push),
        .push_data    (push_data)
    );

    mccac_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    mccac_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_stat            (q_stat),
        .head              (head),
        .pop               (pop),
        .samples_per_trial (spt_reg),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .hit_count         (hit_count)
    );

    // front only pushes into a free slot
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("sample pushed into full queue");

    // back only pops a filled slot
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("sample popped from empty queue");

    // an accepted item keeps the front busy for its second draw
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> sample_stall)
        else $error("front accepted an item while drawing");

endmodule

// File: sim/area_trial_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// area_trial_checker
// Watches the sample, result and register channels of the Monte Carlo cubic
// area counter. It keeps its own copy of the generator, counters and
// registers, works out the hit count of each completed trial as samples are
// accepted, and compares every accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module area_trial_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    input  logic                             sample_stall,
    input  logic                             reseed,
    input  logic                             result_valid,
    input  logic                             result_stall,
    input  logic [mccac_pkg::COUNT_W-1:0]    hit_count,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [mccac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mccac_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                               pending,
    output int                               trials_checked,
    output int                               failures
);

    import mccac_pkg::*;

    localparam logic [30:0]  PM_MOD       = 31'h7FFF_FFFF;
    localparam logic [63:0]  PM_MUL       = 64'd16807;
    localparam logic [30:0]  PM_SEED_INIT = 31'd7994808;
    localparam logic [15:0]  TRIAL_INIT   = 16'd100;
    localparam logic [127:0] TOL_K        = 128'd10000;
    localparam logic [127:0] MOD_W        = {97'd0, PM_MOD};
    localparam logic [127:0] MOD_CUBED    = MOD_W * MOD_W * MOD_W;

    logic [30:0] seed_r;
    logic [15:0] trial_len_r;
    logic [30:0] lehmer_state;
    logic [15:0] samples_in_trial;
    logic [15:0] hits_in_trial;
    logic [15:0] trial_hits_due[$];

    function automatic logic [30:0] lehmer_step(input logic [30:0] s);
        logic [63:0] p;
        p = {33'd0, s} * PM_MUL;
        return 31'(p % {33'd0, PM_MOD});
    endfunction

    // y <= x^3 + 1e-4, scaled by 10000 * M^3 to stay in integers
    function automatic bit under_cubic(input logic [30:0] sx, input logic [30:0] sy);
        logic [127:0] x;
        logic [127:0] lhs;
        logic [127:0] rhs;
        x   = {97'd0, sx};
        lhs = {97'd0, sy} * TOL_K * MOD_W * MOD_W;
        rhs = x * x * x * TOL_K + MOD_CUBED;
        return lhs <= rhs;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t  mismatch: %s", $time, msg);
        failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [30:0] sx;
        logic [30:0] sy;
        logic [15:0] limit;
        logic [15:0] want;
        if (!rst_n)
        begin
            seed_r           = PM_SEED_INIT;
            trial_len_r      = TRIAL_INIT;
            lehmer_state     = PM_SEED_INIT;
            samples_in_trial = '0;
            hits_in_trial    = '0;
            trial_hits_due.delete();
            pending          = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (trial_hits_due.size() == 0)
                begin
                    flag_mismatch($sformatf("hit_count %0d with no trial due", hit_count));
                end
                else
                begin
                    want = trial_hits_due.pop_front();
                    if (hit_count !== want)
                    begin
                        flag_mismatch($sformatf("hit_count expected %0d, got %0d",
                                                want, hit_count));
                    end
                end
                trials_checked++;
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SEED)
                begin
                    seed_r = cfg_data[30:0];
                end
                else if (cfg_index == CFG_SPT)
                begin
                    trial_len_r = cfg_data[15:0];
                end
            end

            if (sample_valid && !sample_stall)
            begin
                if (reseed)
                begin
                    lehmer_state     = seed_r;
                    samples_in_trial = '0;
                    hits_in_trial    = '0;
                end
                sx           = lehmer_step(lehmer_state);
                sy           = lehmer_step(sx);
                lehmer_state = sy;
                if (under_cubic(sx, sy))
                begin
                    hits_in_trial = hits_in_trial + 16'd1;
                end
                samples_in_trial = samples_in_trial + 16'd1;
                // a zero trial length behaves as one
                limit = (trial_len_r == 16'd0) ? 16'd1 : trial_len_r;
                if (samples_in_trial >= limit)
                begin
                    trial_hits_due.push_back(hits_in_trial);
                    samples_in_trial = '0;
                    hits_in_trial    = '0;
                end
            end
            pending = trial_hits_due.size();
        end
    end

endmodule

// File: sim/monte_carlo_cubic_area_counter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// monte_carlo_cubic_area_counter_core_test
// Drives the Monte Carlo cubic area counter with directed corner cases
// (seed extremes, zero and maximal trial lengths, a shortened trial) and
// then random phases of samples under random register settings, with random
// gaps on the sample side and random stalls on the result side.
// ----------------------------------------------------------------------------
module monte_carlo_cubic_area_counter_core_test;
    import mccac_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int SETTLE       = 100;

    logic                  clk;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_stall;
    logic                  reseed;
    logic                  result_valid;
    logic                  result_stall;
    logic [COUNT_W-1:0]    hit_count;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int pending;
    int trials_checked;
    int failures;
    int items_sent;
    int reseeds_sent;
    int settings_used;
    int send_calm;

    monte_carlo_cubic_area_counter_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .reseed       (reseed),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .hit_count    (hit_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    area_trial_checker trial_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .reseed         (reseed),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .hit_count      (hit_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pending        (pending),
        .trials_checked (trials_checked),
        .failures       (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // entered and left on a falling edge
    task automatic push_sample(input logic rs);
        int gap;
        if (send_calm > 0)
        begin
            send_calm--;
            gap = 0;
        end
        else
        begin
            gap = gap_len();
            if ($urandom_range(0, 99) == 0)
            begin
                send_calm = $urandom_range(30, 120);
            end
        end
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid <= 1'b1;
        reseed       <= rs;
        @(posedge clk);
        while (sample_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (rs)
        begin
            reseeds_sent++;
        end
        @(negedge clk);
    endtask

    // hold off until every trial due is back and the back end has gone quiet
    task automatic drain_block();
        sample_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        if (last)
        begin
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic load_setting(input bit do_seed, input logic [CFG_DATA_W-1:0] seed_word,
                                input bit do_len, input logic [CFG_DATA_W-1:0] len_word);
        if (do_seed)
        begin
            write_reg(CFG_SEED, seed_word, !do_len);
        end
        if (do_len)
        begin
            write_reg(CFG_SPT, len_word, 1'b1);
        end
        if (do_seed || do_len)
        begin
            settings_used++;
        end
    endtask

    // result side: random stall runs with occasional calm stretches
    initial
    begin : result_side
        int run;
        int calm;
        run          = 0;
        calm         = 0;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (run > 0)
            begin
                result_stall <= 1'b1;
                run--;
            end
            else
            begin
                result_stall <= 1'b0;
                if (calm > 0)
                begin
                    calm--;
                end
                else if ($urandom_range(0, 199) == 0)
                begin
                    calm = $urandom_range(50, 300);
                end
                else
                begin
                    run = gap_len();
                end
            end
        end
    end

    initial
    begin : stimulus
        int rand_items;
        int phase_len;
        int r;
        bit do_seed;
        bit do_len;
        logic [30:0] seed_word;
        logic [15:0] trial_len;
        logic [14:0] junk;

        sample_valid  = 1'b0;
        reseed        = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_SEED;
        cfg_data      = '0;
        rst_n         = 1'b0;
        items_sent    = 0;
        reseeds_sent  = 0;
        settings_used = 0;
        send_calm     = 0;
        rand_items    = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // generator and trial length as left by reset
        repeat (3) push_sample(1'b0);
        drain_block();
        // trial already past the new length: next sample closes it
        load_setting(1'b0, '0, 1'b1, 31'd2);
        push_sample(1'b0);
        drain_block();
        // seed of zero, zero trial length: every item a one-hit trial
        load_setting(1'b1, 31'd0, 1'b1, 31'd0);
        push_sample(1'b1);
        repeat (2) push_sample(1'b0);
        drain_block();
        // seed equal to the modulus collapses the generator to zero
        load_setting(1'b1, 31'h7FFF_FFFF, 1'b1, 31'd4);
        push_sample(1'b1);
        repeat (3) push_sample(1'b0);
        drain_block();
        load_setting(1'b1, 31'd1, 1'b1, 31'd1);
        push_sample(1'b1);
        push_sample(1'b0);
        drain_block();
        load_setting(1'b1, 31'd2147483646, 1'b1, 31'd65535);
        push_sample(1'b1);
        repeat (3) push_sample(1'b0);
        drain_block();
        load_setting(1'b0, '0, 1'b1, 31'd3);
        push_sample(1'b0);

        while (rand_items < RANDOM_ITEMS)
        begin
            drain_block();
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                seed_word = 31'($urandom_range(1, 2147483646));
            end
            else if (r < 80)
            begin
                seed_word = 31'd0;
            end
            else if (r < 88)
            begin
                seed_word = 31'h7FFF_FFFF;
            end
            else if (r < 94)
            begin
                seed_word = 31'd1;
            end
            else
            begin
                seed_word = 31'd2147483646;
            end
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                trial_len = 16'($urandom_range(1, 8));
            end
            else if (r < 75)
            begin
                trial_len = 16'($urandom_range(9, 40));
            end
            else if (r < 85)
            begin
                trial_len = 16'd0;
            end
            else
            begin
                trial_len = 16'($urandom_range(41, 300));
            end
            // upper data bits are ignored for the trial length
            junk = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'd0;
            r = $urandom_range(0, 99);
            do_seed = (r < 85);
            do_len  = (r < 70) || (r >= 85);
            load_setting(do_seed, seed_word, do_len, {junk, trial_len});

            phase_len = $urandom_range(8, 60);
            for (int k = 0; k < phase_len; k++)
            begin
                if (k == 0)
                begin
                    push_sample($urandom_range(0, 99) < 60);
                end
                else
                begin
                    push_sample($urandom_range(0, 99) < 4);
                end
                rand_items++;
                if ($urandom_range(0, 99) < 3)
                begin
                    drain_block();
                end
            end
        end
        drain_block();

        $display("%0d samples sent (%0d with reseed) under %0d register settings",
                 items_sent, reseeds_sent, settings_used);
        $display("%0d trial hit counts compared", trials_checked);
        if (failures == 0 && pending == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/mccac_pkg.sv
rtl/mccac_front.sv
rtl/mccac_queue.sv
rtl/mccac_back.sv
rtl/monte_carlo_cubic_area_counter_core.sv
sim/area_trial_checker.sv
sim/monte_carlo_cubic_area_counter_core_test.sv
